>>> src/bta_pkg.sv
// shared types, codes and constants of the boundary-tag heap allocator
package bta_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int STORE_WORDS = HEAP_BYTES / 4;
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int AW          = 17;
  localparam int CHUNK_W     = 18;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_RESIZE  = 2'd2;
  localparam logic [1:0] CMD_REBUILD = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_CHUNK = 1'b1;

  typedef struct packed {
    logic [AW-1:0]      lim;
    logic [CHUNK_W-1:0] chunk;
  } bta_cfg_t;

  typedef enum logic [32:0] {
    S_IDLE   = 33'd1 << 0,
    S_LV_RD  = 33'd1 << 1,
    S_LV_CK  = 33'd1 << 2,
    S_REL_A  = 33'd1 << 3,
    S_REL_B  = 33'd1 << 4,
    S_CO_A   = 33'd1 << 5,
    S_CO_B   = 33'd1 << 6,
    S_CO_C   = 33'd1 << 7,
    S_CO_D   = 33'd1 << 8,
    S_CO_E   = 33'd1 << 9,
    S_CO_F   = 33'd1 << 10,
    S_TG_H   = 33'd1 << 11,
    S_TG_F   = 33'd1 << 12,
    S_TK_RD  = 33'd1 << 13,
    S_TK_CK  = 33'd1 << 14,
    S_GR_CHK = 33'd1 << 15,
    S_GR_EPI = 33'd1 << 16,
    S_GR_END = 33'd1 << 17,
    S_CV_RD  = 33'd1 << 18,
    S_CV_CK  = 33'd1 << 19,
    S_CV_T2  = 33'd1 << 20,
    S_AL_END = 33'd1 << 21,
    S_RS_A   = 33'd1 << 22,
    S_RS_B   = 33'd1 << 23,
    S_RS_C   = 33'd1 << 24,
    S_RS_W   = 33'd1 << 25,
    S_RS_T   = 33'd1 << 26,
    S_RB0    = 33'd1 << 27,
    S_RB1    = 33'd1 << 28,
    S_RB2    = 33'd1 << 29,
    S_RB3    = 33'd1 << 30,
    S_RB4    = 33'd1 << 31,
    S_DONE   = 33'd1 << 32
  } bta_state_t;

endpackage

>>> src/bta_cfg.sv
// configuration registers with the effective break limit and rounded growth chunk
module bta_cfg
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  output bta_cfg_t    cfg_o
);

  logic [16:0] limit_r;
  logic [16:0] chunk_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 17'(HEAP_BYTES);
      chunk_r <= 17'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT: limit_r <= cfg_data;
        CFG_CHUNK: chunk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.lim   = (limit_r > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : limit_r;
    cfg_o.chunk = (18'(chunk_r) + 18'd7) & ~18'd7;
  end

endmodule

>>> src/boundary_tag_heap_allocator_unit.sv
// top level of the boundary-tag first-fit heap allocator
//
// in_* carries one command beat: allocate, release, resize or rebuild.
// out_* returns exactly one result beat per command, in order.
// cfg_* writes the break limit (index 0) or the growth chunk (index 1);
// write only while no command is in flight.
// A single-port word store holds the heap; one sequencer walks block tags
// through it, one read or one write per cycle.
// A command's run time grows with each block header visited by the liveness
// walk and the first-fit walk, and with any merge.
// in_tready is high only while the sequencer is idle, so commands are served
// one at a time; the result register lets the next command start while a
// result still waits for out_tready.
// After reset the block lays out the heap before taking a command; store words
// outside that layout are undefined until written.
// A stalled receiver holds the result beat; the next result waits behind it.
module boundary_tag_heap_allocator_unit
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd, block_addr, req_bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // result_addr, status, copy_src, copy_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  bta_cfg_t cfg;

  bta_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  logic [31:0] mem [STORE_WORDS];
  logic [31:0] mem_q_r;
  logic        rd_oob_r;
  logic        mem_re, mem_we;
  logic [AW-1:0] mem_a;
  logic [31:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we && (mem_a < AW'(HEAP_BYTES))) mem[mem_a[IDX_W+1:2]] <= mem_wd;
    if (mem_re) begin
      mem_q_r  <= mem[mem_a[IDX_W+1:2]];
      rd_oob_r <= (mem_a >= AW'(HEAP_BYTES));
    end
  end

  logic [31:0]   rd_val;
  logic [AW-1:0] rsz;
  logic          ral;
  assign rd_val = rd_oob_r ? 32'd0 : mem_q_r;
  assign rsz    = {rd_val[16:3], 3'b000};
  assign ral    = rd_val[0];

  bta_state_t state_r, state_nxt;
  bta_state_t tag_ret_r, tag_ret_nxt, coal_ret_r, coal_ret_nxt;
  bta_state_t carve_ret_r, carve_ret_nxt, take_ret_r, take_ret_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic [AW-1:0] need_r, need_nxt, p_r, p_nxt, bp_r, bp_nxt, bs_r, bs_nxt;
  logic [AW-1:0] csz_r, csz_nxt, pb_r, pb_nxt, cvs_r, cvs_nxt, brk_r, brk_nxt;
  logic [AW-1:0] tg_bp_r, tg_bp_nxt, tg_sz_r, tg_sz_nxt;
  logic          tg_al_r, tg_al_nxt, pfree_r, pfree_nxt, nfree_r, nfree_nxt;
  logic          tk_ok_r, tk_ok_nxt, boot_r, boot_nxt;
  logic [CHUNK_W-1:0] gr_r, gr_nxt;
  logic [15:0]   res_r, res_nxt, src_r, src_nxt, cnt_r, cnt_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          out_valid_r;
  logic [55:0]   out_data_r;
  logic          out_load;

  logic [1:0]  in_cmd;
  logic [15:0] in_addr, in_req;
  assign in_cmd  = in_tdata[1:0];
  assign in_addr = in_tdata[17:2];
  assign in_req  = in_tdata[33:18];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    logic [1:0]    ecmd;
    logic          lv_fin, lv_live;
    logic [18:0]   gsum;
    logic [CHUNK_W-1:0] need_x;
    state_nxt = state_r;
    tag_ret_nxt = tag_ret_r; coal_ret_nxt = coal_ret_r;
    carve_ret_nxt = carve_ret_r; take_ret_nxt = take_ret_r;
    cmd_nxt = cmd_r; addr_nxt = addr_r; need_nxt = need_r; p_nxt = p_r;
    bp_nxt = bp_r; bs_nxt = bs_r; csz_nxt = csz_r; pb_nxt = pb_r; cvs_nxt = cvs_r;
    brk_nxt = brk_r; tg_bp_nxt = tg_bp_r; tg_sz_nxt = tg_sz_r; tg_al_nxt = tg_al_r;
    pfree_nxt = pfree_r; nfree_nxt = nfree_r; tk_ok_nxt = tk_ok_r; boot_nxt = boot_r;
    gr_nxt = gr_r; res_nxt = res_r; src_nxt = src_r; cnt_nxt = cnt_r; st_nxt = st_r;
    mem_re = 1'b0; mem_we = 1'b0; mem_a = '0; mem_wd = '0;
    out_load = 1'b0;
    lv_fin = 1'b0; lv_live = 1'b0;
    ecmd = in_cmd;
    need_x = 18'(need_r);
    gsum = 19'(brk_r) + 19'(gr_r);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (ecmd == CMD_RESIZE && in_addr == 16'd0) ecmd = CMD_ALLOC;
          if (ecmd == CMD_RESIZE && in_req == 16'd0) ecmd = CMD_RELEASE;
          cmd_nxt = ecmd; addr_nxt = in_addr;
          need_nxt = (in_req <= 16'd8) ? AW'(16) : ((AW'(in_req) + AW'(15)) & ~AW'(7));
          res_nxt = '0; st_nxt = ST_OK; src_nxt = '0; cnt_nxt = '0;
          p_nxt = AW'(16);
          case (ecmd)
            CMD_ALLOC: begin
              if (in_req == 16'd0) begin
                st_nxt = ST_NONE; state_nxt = S_DONE;
              end else begin
                p_nxt = AW'(8); tk_ok_nxt = 1'b0;
                take_ret_nxt = S_AL_END; carve_ret_nxt = S_AL_END;
                state_nxt = S_TK_RD;
              end
            end
            CMD_RELEASE: begin
              st_nxt = ST_NONE; state_nxt = S_LV_RD;
            end
            CMD_RESIZE: state_nxt = S_LV_RD;
            default: state_nxt = S_RB0;
          endcase
        end
      end
      S_LV_RD: begin
        if (p_r < brk_r && p_r <= AW'(addr_r)) begin
          mem_re = 1'b1; mem_a = p_r - AW'(4); state_nxt = S_LV_CK;
        end else begin
          lv_fin = 1'b1;
        end
      end
      S_LV_CK: begin
        if (rsz == '0) lv_fin = 1'b1;
        else if (p_r == AW'(addr_r)) begin
          lv_fin = 1'b1; lv_live = ral;
        end else begin
          p_nxt = p_r + rsz; state_nxt = S_LV_RD;
        end
      end
      S_REL_A: begin
        mem_re = 1'b1; mem_a = bp_r - AW'(4); state_nxt = S_REL_B;
      end
      S_REL_B: begin
        tg_bp_nxt = bp_r; tg_sz_nxt = rsz; tg_al_nxt = 1'b0;
        tag_ret_nxt = S_CO_A; state_nxt = S_TG_H;
      end
      S_CO_A: begin
        mem_re = 1'b1; mem_a = bp_r - AW'(4); state_nxt = S_CO_B;
      end
      S_CO_B: begin
        csz_nxt = rsz;
        mem_re = 1'b1; mem_a = bp_r - AW'(8); state_nxt = S_CO_C;
      end
      S_CO_C: begin
        pfree_nxt = !ral; pb_nxt = bp_r - rsz;
        mem_re = 1'b1; mem_a = bp_r + csz_r - AW'(4); state_nxt = S_CO_D;
      end
      S_CO_D: begin
        nfree_nxt = !ral;
        if (!ral) csz_nxt = csz_r + rsz;
        if (pfree_r) begin
          mem_re = 1'b1; mem_a = pb_r - AW'(4); state_nxt = S_CO_E;
        end else begin
          state_nxt = S_CO_F;
        end
      end
      S_CO_E: begin
        csz_nxt = csz_r + rsz; bp_nxt = pb_r; state_nxt = S_CO_F;
      end
      S_CO_F: begin
        if (pfree_r || nfree_r) begin
          tg_bp_nxt = bp_r; tg_sz_nxt = csz_r; tg_al_nxt = 1'b0;
          tag_ret_nxt = coal_ret_r; state_nxt = S_TG_H;
        end else begin
          state_nxt = coal_ret_r;
        end
      end
      S_TG_H: begin
        mem_we = 1'b1; mem_a = tg_bp_r - AW'(4);
        mem_wd = 32'(tg_sz_r) | 32'(tg_al_r); state_nxt = S_TG_F;
      end
      S_TG_F: begin
        mem_we = 1'b1; mem_a = tg_bp_r + tg_sz_r - AW'(8);
        mem_wd = 32'(tg_sz_r) | 32'(tg_al_r); state_nxt = tag_ret_r;
      end
      S_TK_RD: begin
        if (p_r < brk_r) begin
          mem_re = 1'b1; mem_a = p_r - AW'(4); state_nxt = S_TK_CK;
        end else begin
          gr_nxt = (need_x > cfg.chunk) ? need_x : cfg.chunk; state_nxt = S_GR_CHK;
        end
      end
      S_TK_CK: begin
        if (rsz == '0) begin
          gr_nxt = (need_x > cfg.chunk) ? need_x : cfg.chunk; state_nxt = S_GR_CHK;
        end else if (!ral && need_r <= rsz) begin
          bp_nxt = p_r; tk_ok_nxt = 1'b1; state_nxt = S_CV_RD;
        end else begin
          p_nxt = p_r + rsz; state_nxt = S_TK_RD;
        end
      end
      S_GR_CHK: begin
        if (gr_r == '0 || gsum > 19'(cfg.lim)) begin
          if (cmd_r == CMD_REBUILD) begin
            st_nxt = ST_OOM; state_nxt = S_DONE;
          end else begin
            tk_ok_nxt = 1'b0; state_nxt = take_ret_r;
          end
        end else begin
          bp_nxt = brk_r; tg_bp_nxt = brk_r; tg_sz_nxt = gr_r[AW-1:0];
          tg_al_nxt = 1'b0; tag_ret_nxt = S_GR_EPI; state_nxt = S_TG_H;
        end
      end
      S_GR_EPI: begin
        mem_we = 1'b1; mem_a = brk_r + gr_r[AW-1:0] - AW'(4); mem_wd = 32'd1;
        brk_nxt = brk_r + gr_r[AW-1:0];
        coal_ret_nxt = S_GR_END; state_nxt = S_CO_A;
      end
      S_GR_END: begin
        if (cmd_r == CMD_REBUILD) begin
          st_nxt = ST_OK; state_nxt = S_DONE;
        end else begin
          tk_ok_nxt = 1'b1; state_nxt = S_CV_RD;
        end
      end
      S_CV_RD: begin
        mem_re = 1'b1; mem_a = bp_r - AW'(4); state_nxt = S_CV_CK;
      end
      S_CV_CK: begin
        cvs_nxt = rsz; tg_bp_nxt = bp_r; tg_al_nxt = 1'b1; state_nxt = S_TG_H;
        if (18'(rsz) >= 18'(need_r) + 18'd8) begin
          tg_sz_nxt = need_r; tag_ret_nxt = S_CV_T2;
        end else begin
          tg_sz_nxt = rsz; tag_ret_nxt = carve_ret_r;
        end
      end
      S_CV_T2: begin
        tg_bp_nxt = bp_r + need_r; tg_sz_nxt = cvs_r - need_r; tg_al_nxt = 1'b0;
        tag_ret_nxt = carve_ret_r; state_nxt = S_TG_H;
      end
      S_AL_END: begin
        res_nxt = tk_ok_r ? bp_r[15:0] : 16'd0;
        st_nxt = tk_ok_r ? ST_OK : ST_OOM; state_nxt = S_DONE;
      end
      S_RS_A: begin
        mem_re = 1'b1; mem_a = AW'(addr_r) - AW'(4); state_nxt = S_RS_B;
      end
      S_RS_B: begin
        bs_nxt = rsz;
        mem_re = 1'b1; mem_a = AW'(addr_r) + rsz - AW'(4); state_nxt = S_RS_C;
      end
      S_RS_C: begin
        res_nxt = addr_r; bp_nxt = AW'(addr_r);
        if (need_r < bs_r) begin
          carve_ret_nxt = S_DONE; state_nxt = S_CV_RD;
        end else if (need_r == bs_r) begin
          state_nxt = S_DONE;
        end else if (!ral && (18'(rsz) + 18'(bs_r) >= 18'(need_r))) begin
          csz_nxt = rsz + bs_r; state_nxt = S_RS_W;
        end else begin
          p_nxt = AW'(8); tk_ok_nxt = 1'b0;
          take_ret_nxt = S_RS_T; carve_ret_nxt = S_RS_T; state_nxt = S_TK_RD;
        end
      end
      S_RS_W: begin
        mem_we = 1'b1; mem_a = AW'(addr_r) - AW'(4); mem_wd = 32'(csz_r);
        carve_ret_nxt = S_DONE; state_nxt = S_CV_RD;
      end
      S_RS_T: begin
        if (!tk_ok_r) begin
          res_nxt = '0; st_nxt = ST_OOM; state_nxt = S_DONE;
        end else begin
          res_nxt = bp_r[15:0]; src_nxt = addr_r; cnt_nxt = 16'(bs_r - AW'(8));
          bp_nxt = AW'(addr_r); coal_ret_nxt = S_DONE; state_nxt = S_REL_A;
        end
      end
      S_RB0: begin
        mem_we = 1'b1; mem_a = AW'(0); mem_wd = 32'd0; state_nxt = S_RB1;
      end
      S_RB1: begin
        mem_we = 1'b1; mem_a = AW'(4); mem_wd = 32'd9; state_nxt = S_RB2;
      end
      S_RB2: begin
        mem_we = 1'b1; mem_a = AW'(8); mem_wd = 32'd9; state_nxt = S_RB3;
      end
      S_RB3: begin
        mem_we = 1'b1; mem_a = AW'(12); mem_wd = 32'd1; state_nxt = S_RB4;
      end
      S_RB4: begin
        brk_nxt = AW'(16); st_nxt = ST_OK;
        if (cfg.chunk == '0) state_nxt = S_DONE;
        else begin
          gr_nxt = cfg.chunk; state_nxt = S_GR_CHK;
        end
      end
      S_DONE: begin
        if (boot_r) begin
          boot_nxt = 1'b0; state_nxt = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (lv_fin) begin
      if (cmd_r == CMD_RELEASE) begin
        if (lv_live) begin
          bp_nxt = AW'(addr_r); coal_ret_nxt = S_DONE; state_nxt = S_REL_A;
        end else begin
          state_nxt = S_DONE;
        end
      end else if (lv_live) begin
        state_nxt = S_RS_A;
      end else begin
        st_nxt = ST_OOM; state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RB0;
      cmd_r       <= CMD_REBUILD;
      boot_r      <= 1'b1;
      brk_r       <= AW'(16);
      out_valid_r <= 1'b0;
      tag_ret_r   <= S_IDLE;
      coal_ret_r  <= S_IDLE;
      carve_ret_r <= S_IDLE;
      take_ret_r  <= S_IDLE;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      boot_r      <= boot_nxt;
      brk_r       <= brk_nxt;
      tag_ret_r   <= tag_ret_nxt;
      coal_ret_r  <= coal_ret_nxt;
      carve_ret_r <= carve_ret_nxt;
      take_ret_r  <= take_ret_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; need_r <= need_nxt; p_r <= p_nxt; bp_r <= bp_nxt;
    bs_r <= bs_nxt; csz_r <= csz_nxt; pb_r <= pb_nxt; cvs_r <= cvs_nxt;
    tg_bp_r <= tg_bp_nxt; tg_sz_r <= tg_sz_nxt; tg_al_r <= tg_al_nxt;
    pfree_r <= pfree_nxt; nfree_r <= nfree_nxt; tk_ok_r <= tk_ok_nxt; gr_r <= gr_nxt;
    res_r <= res_nxt; src_r <= src_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt;
    if (out_load) out_data_r <= {6'd0, cnt_r, src_r, st_r, res_r};
  end

  property p_brk_aligned;
    @(posedge clk) disable iff (!rst_n) brk_r[2:0] == 3'b000;
  endproperty
  a_brk_aligned: assert property (p_brk_aligned) else $error("break misaligned");

  property p_accept_leaves_idle;
    @(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> state_r != S_IDLE;
  endproperty
  a_accept_leaves_idle: assert property (p_accept_leaves_idle)
    else $error("sequencer stayed idle after a beat");

  property p_result_from_done;
    @(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(state_r == S_DONE);
  endproperty
  a_result_from_done: assert property (p_result_from_done)
    else $error("result beat raised outside completion");

  property p_no_rw_clash;
    @(posedge clk) disable iff (!rst_n) !(mem_re && mem_we);
  endproperty
  a_no_rw_clash: assert property (p_no_rw_clash) else $error("store read and write together");

endmodule

>>> tb/boundary_tag_heap_allocator_unit_tb.sv
// self-checking testbench for the boundary-tag heap allocator unit
module boundary_tag_heap_allocator_unit_tb;
  import bta_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int LONG_HOLD       = 3000;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  st;
    logic [15:0] src;
    logic [15:0] cnt;
  } alloc_res_t;

  class heap_scoreboard;
    bit [31:0] mem [STORE_WORDS];
    int unsigned brk, lim_reg, chunk_reg;
    alloc_res_t pending[$];
    int errors, checked, n_oom, n_move;

    function new();
      foreach (mem[i]) mem[i] = '0;
      lim_reg = 65536;
      chunk_reg = 4096;
      void'(rebuild());
    endfunction

    function int unsigned rd(int unsigned a);
      return ((a >> 2) < STORE_WORDS) ? mem[a >> 2] : 0;
    endfunction

    function void wr(int unsigned a, int unsigned v);
      if ((a >> 2) < STORE_WORDS) mem[a >> 2] = v;
    endfunction

    function int unsigned bsize(int unsigned bp);
      return rd(bp - 4) & ~32'h7;
    endfunction

    function bit busy(int unsigned bp);
      return (rd(bp - 4) & 1) != 0;
    endfunction

    function void tag(int unsigned bp, int unsigned size, bit al);
      wr(bp - 4, size | al);
      wr(bp + size - 8, size | al);
    endfunction

    function int unsigned lim_now();
      int unsigned l;
      l = lim_reg;
      if (l > HEAP_BYTES) l = HEAP_BYTES;
      if (l > 65536) l = 65536;
      return l;
    endfunction

    function int unsigned chunk_now();
      return (chunk_reg + 7) & ~32'h7;
    endfunction

    function int unsigned merge(int unsigned bp);
      int unsigned size, nb, pb;
      bit pfree, nfree;
      size = bsize(bp);
      nb = bp + size;
      pfree = !(rd(bp - 8) & 1);
      nfree = !busy(nb);
      pb = bp - (rd(bp - 8) & ~32'h7);
      if (nfree) size += bsize(nb);
      if (pfree) begin
        size += bsize(pb);
        bp = pb;
      end
      if (pfree || nfree) tag(bp, size, 0);
      return bp;
    endfunction

    function int unsigned extend(int unsigned bytes);
      int unsigned bp;
      bp = brk;
      if (bytes == 0 || bp + bytes > lim_now()) return 0;
      tag(bp, bytes, 0);
      wr(bp + bytes - 4, 1);
      brk = bp + bytes;
      return merge(bp);
    endfunction

    function int unsigned first_free(int unsigned need);
      int unsigned p, s;
      p = 8;
      for (int n = 0; n < STORE_WORDS && p < brk; n++) begin
        s = bsize(p);
        if (s == 0) break;
        if (!busy(p) && need <= s) return p;
        p += s;
      end
      return 0;
    endfunction

    function bit is_live(int unsigned a);
      int unsigned p, s;
      p = 16;
      for (int n = 0; n < STORE_WORDS && p < brk && p <= a; n++) begin
        s = bsize(p);
        if (s == 0) break;
        if (p == a) return busy(p);
        p += s;
      end
      return 0;
    endfunction

    // random allocated payload offset, 0 when the heap holds none
    function int unsigned pick_live(output int live_cnt);
      int unsigned p, s;
      int unsigned found[$];
      p = 16;
      for (int n = 0; n < STORE_WORDS && p < brk; n++) begin
        s = bsize(p);
        if (s == 0) break;
        if (busy(p)) found.push_back(p);
        p += s;
      end
      live_cnt = found.size();
      if (found.size() == 0) return 0;
      return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function void carve(int unsigned bp, int unsigned need);
      int unsigned size;
      size = bsize(bp);
      if (size >= need + 8) begin
        tag(bp, need, 1);
        tag(bp + need, size - need, 0);
      end else begin
        tag(bp, size, 1);
      end
    endfunction

    function int unsigned block_need(int unsigned q);
      return (q <= 8) ? 16 : 8 * ((q + 15) / 8);
    endfunction

    function int unsigned take(int unsigned need);
      int unsigned bp, c;
      bp = first_free(need);
      if (bp == 0) begin
        c = chunk_now();
        bp = extend(need > c ? need : c);
      end
      if (bp != 0) carve(bp, need);
      return bp;
    endfunction

    function void free_block(int unsigned bp);
      tag(bp, bsize(bp), 0);
      void'(merge(bp));
    endfunction

    function logic [1:0] rebuild();
      wr(0, 0);
      wr(4, 9);
      wr(8, 9);
      wr(12, 1);
      brk = 16;
      if (chunk_now() == 0) return ST_OK;
      return (extend(chunk_now()) != 0) ? ST_OK : ST_OOM;
    endfunction

    function void write_reg(logic idx, logic [16:0] v);
      if (idx == CFG_LIMIT) lim_reg = 32'(v);
      else chunk_reg = 32'(v);
    endfunction

    function alloc_res_t note_input(logic [1:0] c, logic [15:0] a, logic [15:0] q);
      alloc_res_t r;
      int unsigned need, bs, nb, sum, got;
      r = '{default: '0};
      if (c == CMD_RESIZE && a == 0) c = CMD_ALLOC;
      if (c == CMD_RESIZE && q == 0) c = CMD_RELEASE;
      case (c)
        CMD_ALLOC: begin
          if (q == 0) r.st = ST_NONE;
          else begin
            got = take(block_need(q));
            r.addr = 16'(got);
            r.st = (got != 0) ? ST_OK : ST_OOM;
          end
        end
        CMD_RELEASE: begin
          if (is_live(a)) free_block(a);
          r.st = ST_NONE;
        end
        CMD_REBUILD: r.st = rebuild();
        default: begin
          if (!is_live(a)) r.st = ST_OOM;
          else begin
            need = block_need(q);
            bs = bsize(a);
            nb = a + bs;
            sum = bsize(nb) + bs;
            r.addr = a;
            if (need < bs) carve(a, need);
            else if (need > bs) begin
              if (!busy(nb) && sum >= need) begin
                wr(a - 4, sum);
                carve(a, need);
              end else begin
                got = take(need);
                r.addr = 16'(got);
                if (got == 0) r.st = ST_OOM;
                else begin
                  r.src = a;
                  r.cnt = 16'(bs - 8);
                  free_block(a);
                end
              end
            end
          end
        end
      endcase
      if (r.st == ST_OOM) n_oom++;
      if (r.cnt != 0) n_move++;
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(logic [55:0] d);
      alloc_res_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[15:0] !== e.addr) begin
        $error("result_addr expected %0d actual %0d", e.addr, d[15:0]);
        errors++;
      end
      if (d[17:16] !== e.st) begin
        $error("status expected %0d actual %0d", e.st, d[17:16]);
        errors++;
      end
      if (d[33:18] !== e.src) begin
        $error("copy_src expected %0d actual %0d", e.src, d[33:18]);
        errors++;
      end
      if (d[49:34] !== e.cnt) begin
        $error("copy_bytes expected %0d actual %0d", e.cnt, d[49:34]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [16:0] cfg_data = '0;

  heap_scoreboard sb = new();
  int  hold_cnt = 0;
  bit  hold_long = 0;
  bit  steady = 0;
  int  idle_cycles = 0;
  int  cmd_count[4] = '{0, 0, 0, 0};

  boundary_tag_heap_allocator_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 0;
    end else if (hold_long) begin
      hold_long = 0;
      hold_cnt = LONG_HOLD;
      out_tready <= 0;
    end else if (steady) begin
      out_tready <= 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) out_tready <= 1;
      else begin
        out_tready <= 0;
        hold_cnt = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic [1:0] c, input logic [15:0] a, input logic [15:0] q,
                      output alloc_res_t e);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = (steady || r < 50) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, q, a, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = sb.note_input(c, a, q);
    cmd_count[c]++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.write_reg(idx, v);
  endtask

  function automatic logic [15:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 64));
    if (r < 90) return 16'($urandom_range(65, 1024));
    if (r < 97) return 16'($urandom_range(1025, 8192));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_items(input int n, input bit pressure);
    alloc_res_t e;
    int unsigned a;
    int live, r;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_long = 1;
      if (pressure && i == 2 * n / 3) drain();
      a = sb.pick_live(live);
      r = $urandom_range(0, 99);
      if (live > 40) r = (r < 50) ? 45 : r;
      if (r < 40 || (a == 0 && r < 70))
        send(CMD_ALLOC, 16'($urandom_range(0, 65535)),
             ($urandom_range(0, 40) == 0) ? 16'd0 : rand_size(), e);
      else if (r < 65) send(CMD_RELEASE, 16'(a), 16'($urandom_range(0, 65535)), e);
      else if (r < 88)
        send(CMD_RESIZE, 16'(a), ($urandom_range(0, 30) == 0) ? 16'd0 : rand_size(), e);
      else if (r < 98)
        send(r[0] ? CMD_RELEASE : CMD_RESIZE, 16'($urandom_range(0, 65535)), rand_size(), e);
      else
        send(CMD_REBUILD, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), e);
    end
    drain();
  endtask

  initial begin
    alloc_res_t e, a1, a2, a3, a4;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corner cases on the reset layout
    send(CMD_ALLOC, 16'h0000, 16'd0, e);
    send(CMD_ALLOC, 16'hffff, 16'd1, a1);
    send(CMD_ALLOC, 16'h0000, 16'd8, a2);
    send(CMD_ALLOC, 16'h0000, 16'd9, a3);
    send(CMD_ALLOC, 16'h0000, 16'hffff, e);
    send(CMD_RELEASE, 16'h0000, 16'hffff, e);
    send(CMD_RELEASE, a1.addr + 16'd4, 16'd0, e);
    send(CMD_RELEASE, a2.addr, 16'd0, e);
    send(CMD_RELEASE, a2.addr, 16'd0, e);
    send(CMD_RESIZE, a1.addr, 16'd32, e);
    send(CMD_RESIZE, 16'h0000, 16'd24, a4);
    send(CMD_RESIZE, a3.addr, 16'd10, e);
    send(CMD_RESIZE, a3.addr, 16'd200, a3);
    send(CMD_RESIZE, a3.addr, 16'd8, e);
    send(CMD_RESIZE, a4.addr, 16'd0, e);
    send(CMD_RESIZE, 16'h0003, 16'd40, e);
    send(CMD_RESIZE, a1.addr, 16'd65535, e);
    send(CMD_REBUILD, 16'hffff, 16'hffff, e);
    drain();

    random_items(200, 0);

    write_reg(CFG_LIMIT, 17'd65536);
    write_reg(CFG_CHUNK, 17'd8);
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(200, 1);

    steady = 1;
    write_reg(CFG_LIMIT, 17'd16);
    write_reg(CFG_CHUNK, 17'd8);
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(40, 0);
    steady = 0;

    write_reg(CFG_LIMIT, 17'd65536);
    write_reg(CFG_CHUNK, 17'd65536);
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(200, 0);

    write_reg(CFG_LIMIT, 17'd1024);
    write_reg(CFG_CHUNK, 17'd61);
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(200, 0);

    write_reg(CFG_CHUNK, 17'd0);
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(30, 0);

    write_reg(CFG_LIMIT, 17'($urandom_range(4096, 65536)));
    write_reg(CFG_CHUNK, 17'($urandom_range(8, 2048)));
    send(CMD_REBUILD, 16'd0, 16'd0, e);
    random_items(320, 0);

    $display("covered %0d allocate, %0d release, %0d resize, %0d rebuild commands",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("checked %0d results, %0d out of memory, %0d moves", sb.checked, sb.n_oom,
             sb.n_move);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> sim.f
src/bta_pkg.sv
src/bta_cfg.sv
src/boundary_tag_heap_allocator_unit.sv
tb/boundary_tag_heap_allocator_unit_tb.sv
